/* rtl/core/bmsp_pkg.sv */
`default_nettype none
package bmsp_pkg;

	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;

	// input modes
	localparam logic [2:0] MODE_COEF = 3'd0;
	localparam logic [2:0] MODE_RHS  = 3'd1;
	localparam logic [2:0] MODE_COST = 3'd2;
	localparam logic [2:0] MODE_OBJ  = 3'd3;
	localparam logic [2:0] MODE_EVAL = 3'd4;

	// result status
	localparam logic [1:0] ST_PIVOT     = 2'd0;
	localparam logic [1:0] ST_OPTIMAL   = 2'd1;
	localparam logic [1:0] ST_UNBOUNDED = 2'd2;

	// register indexes
	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_VARS = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/bmsp_mul.sv */
`default_nettype none
// Shared signed multiplier, one register after the product.
module bmsp_mul (
	input  wire                                       clk,
	input  wire logic signed [bmsp_pkg::DATA_W-1:0]   a,
	input  wire logic signed [bmsp_pkg::DATA_W-1:0]   b,
	output logic signed [bmsp_pkg::PROD_W-1:0]        prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule
`default_nettype wire

/* rtl/core/big_m_simplex_pivot_select_unit.sv */
`default_nettype none
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+--------------------------------------
// in       | in        | in_valid / in_stall  | mode, row, col, value, cost_is_big_m
// out      | out       | out_valid / out_stall| status, pivot_row, pivot_col, sums
// cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// A load beat writes its store and leaves the input open. An evaluate beat walks
// the tableau through one shared multiplier: it accumulates each column against the
// row costs into its estimates, sums the rows, picks, then searches the tie columns,
// runs the ratio test over the rows of each tested column, and posts the result.
// Reset clears the sequencer and sets both registers to one; stores hold garbage until loaded.
// in_stall is high from an evaluate beat until its result is posted; posting waits
// while an earlier result beat is still stalled on out.
module big_m_simplex_pivot_select_unit #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_VARS = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [2:0]         mode,
	input  wire  [2:0]         row,
	input  wire  [4:0]         col,
	input  wire  signed [31:0] value,
	input  wire                cost_is_big_m,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [1:0]         status,
	output logic [2:0]         pivot_row,
	output logic [4:0]         pivot_col,
	output logic signed [47:0] real_sum,
	output logic signed [47:0] big_m_sum,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [3:0]         cfg_data
);

	localparam int NCOLS     = MAX_VARS + 2 * MAX_ROWS;
	localparam int MEM_DEPTH = MAX_ROWS * NCOLS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int RI_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CI_W      = $clog2(NCOLS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EA   = 4'd1;
	localparam logic [3:0] S_EB   = 4'd2;
	localparam logic [3:0] S_EC   = 4'd3;
	localparam logic [3:0] S_ED   = 4'd4;
	localparam logic [3:0] S_SA   = 4'd5;
	localparam logic [3:0] S_SB   = 4'd6;
	localparam logic [3:0] S_PICK = 4'd7;
	localparam logic [3:0] S_TIE  = 4'd8;
	localparam logic [3:0] S_RA   = 4'd9;
	localparam logic [3:0] S_RB   = 4'd10;
	localparam logic [3:0] S_RC   = 4'd11;
	localparam logic [3:0] S_RD   = 4'd12;
	localparam logic [3:0] S_RE   = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	function automatic logic signed [47:0] sat48(input logic signed [55:0] x);
		logic signed [47:0] y;
		if ((&x[55:47]) || !(|x[55:47])) y = x[47:0];
		else if (x[55]) y = {1'b1, 47'd0};
		else y = {1'b0, {47{1'b1}}};
		return y;
	endfunction

	// control
	logic [3:0]      state_q;
	logic [3:0]      num_rows_q, num_vars_q;
	logic [RI_W-1:0] r_q;
	logic [CI_W-1:0] c_q;
	logic            found_q, sel_m_q, out_valid_q;

	// stores
	logic signed [31:0] coef_mem [MEM_DEPTH];
	logic signed [31:0] coef_rd_q;
	logic signed [31:0] rhs_q [MAX_ROWS];
	logic signed [31:0] cost_q [MAX_ROWS];
	logic               bigm_q [MAX_ROWS];
	logic [4:0]         basis_q [MAX_ROWS];
	logic signed [31:0] obj_q [NCOLS];
	logic signed [47:0] rest_q [NCOLS];
	logic signed [47:0] mest_q [NCOLS];

	// datapath
	logic signed [55:0] acc_q, rsum_q;
	logic signed [39:0] macc_q, msum_q;
	logic               basic_q;
	logic signed [47:0] min_r_q, min_m_q, best_q;
	logic signed [63:0] lhs_q;
	logic [RI_W-1:0]    best_r_q;
	logic signed [31:0] ab_q, rhsb_q;
	logic [1:0]         res_status_q;
	logic [2:0]         res_row_q;
	logic [4:0]         res_col_q;
	logic signed [47:0] res_real_q, res_m_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_s1;

	logic [31:0]        rows_n, vars_n;
	logic [RI_W-1:0]    rows_last;
	logic [CI_W-1:0]    cols_last;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic               in_acc, row_ok, col_ok, r_last, c_last, c_zero;
	logic               a_pos, take_first, better;
	logic signed [47:0] real_v, m_v, tie_v;
	logic [1:0]         fin_status;

	bmsp_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// clamp registers and derive loop bounds
	always_comb begin
		if (num_rows_q == 4'd0) rows_n = 32'd1;
		else if (32'(num_rows_q) > MAX_ROWS) rows_n = 32'(MAX_ROWS);
		else rows_n = 32'(num_rows_q);
		if (num_vars_q == 4'd0) vars_n = 32'd1;
		else if (32'(num_vars_q) > MAX_VARS) vars_n = 32'(MAX_VARS);
		else vars_n = 32'(num_vars_q);
		rows_last = RI_W'(rows_n - 32'd1);
		cols_last = CI_W'(vars_n + 2 * rows_n - 32'd1);
	end

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign row_ok     = 32'(row) < MAX_ROWS;
	assign col_ok     = 32'(col) < NCOLS;
	assign rd_addr    = ADDR_W'(32'(r_q) * NCOLS + 32'(c_q));
	assign wr_addr    = ADDR_W'(32'(row) * NCOLS + 32'(col));
	assign r_last     = (r_q == rows_last);
	assign c_last     = (c_q == cols_last);
	assign c_zero     = (c_q == '0);
	assign a_pos      = (coef_rd_q > 32'sd0);
	assign take_first = a_pos && !found_q;
	assign better     = (lhs_q < prod_s1);
	assign real_v     = sat48(acc_q - 56'(obj_q[c_q]));
	assign m_v        = basic_q ? 48'sd0 : 48'(macc_q);
	assign tie_v      = sel_m_q ? mest_q[c_q] : rest_q[c_q];
	assign fin_status = found_q ? bmsp_pkg::ST_PIVOT : bmsp_pkg::ST_UNBOUNDED;

	// steer the shared multiplier
	always_comb begin
		mul_a = coef_rd_q;
		mul_b = cost_q[r_q];
		case (state_q)
			S_SA: begin
				mul_a = rhs_q[r_q];
				mul_b = cost_q[r_q];
			end
			S_RB: begin
				mul_a = rhs_q[r_q];
				mul_b = ab_q;
			end
			S_RC: begin
				mul_a = rhsb_q;
				mul_b = coef_rd_q;
			end
			default: begin
				mul_a = coef_rd_q;
				mul_b = cost_q[r_q];
			end
		endcase
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (in_acc && mode == bmsp_pkg::MODE_COEF && row_ok && col_ok)
			coef_mem[wr_addr] <= value;
		coef_rd_q <= coef_mem[rd_addr];
	end

	// small stores
	always_ff @(posedge clk) begin
		if (in_acc && row_ok && mode == bmsp_pkg::MODE_RHS)
			rhs_q[RI_W'(row)] <= value;
		if (in_acc && row_ok && mode == bmsp_pkg::MODE_COST) begin
			cost_q[RI_W'(row)]  <= value;
			bigm_q[RI_W'(row)]  <= cost_is_big_m;
			basis_q[RI_W'(row)] <= col;
		end
		if (in_acc && col_ok && mode == bmsp_pkg::MODE_OBJ)
			obj_q[CI_W'(col)] <= value;
		if (state_q == S_ED) begin
			rest_q[c_q] <= real_v;
			mest_q[c_q] <= m_v;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_rows_q  <= 4'd1;
			num_vars_q  <= 4'd1;
			r_q         <= '0;
			c_q         <= '0;
			found_q     <= 1'b0;
			sel_m_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bmsp_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data;
					bmsp_pkg::CFG_NUM_VARS: num_vars_q <= cfg_data;
				endcase
			end
			// raise on a posted beat, drop once taken
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && mode == bmsp_pkg::MODE_EVAL) begin
						r_q     <= '0;
						c_q     <= '0;
						state_q <= S_EA;
					end
				end
				S_EA: state_q <= S_EB;
				S_EB: state_q <= S_EC;
				S_EC: begin
					if (r_last) state_q <= S_ED;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_EA;
					end
				end
				S_ED: begin
					r_q <= '0;
					if (c_last) state_q <= S_SA;
					else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_EA;
					end
				end
				S_SA: state_q <= S_SB;
				S_SB: begin
					if (r_last) state_q <= S_PICK;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_SA;
					end
				end
				S_PICK: begin
					c_q     <= cols_last;
					sel_m_q <= (min_m_q < 48'sd0);
					if (min_m_q < 48'sd0 || min_r_q < 48'sd0) state_q <= S_TIE;
					else state_q <= S_OUT;
				end
				S_TIE: begin
					if (tie_v == best_q) begin
						r_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_RA;
					end else if (c_zero) begin
						found_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						c_q <= c_q - 1'b1;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					if (a_pos && found_q) state_q <= S_RC;
					else begin
						if (take_first) found_q <= 1'b1;
						if (r_last) state_q <= S_RE;
						else begin
							r_q     <= r_q + 1'b1;
							state_q <= S_RA;
						end
					end
				end
				S_RC: state_q <= S_RD;
				S_RD: begin
					if (r_last) state_q <= S_RE;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_RA;
					end
				end
				S_RE: begin
					if (found_q || c_zero) state_q <= S_OUT;
					else begin
						c_q     <= c_q - 1'b1;
						state_q <= S_TIE;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// accumulators and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q        <= '0;
				macc_q       <= '0;
				basic_q      <= 1'b0;
				rsum_q       <= '0;
				msum_q       <= '0;
				res_status_q <= bmsp_pkg::ST_OPTIMAL;
			end
			S_EC: begin
				if (bigm_q[r_q]) macc_q <= macc_q - 40'(coef_rd_q);
				else acc_q <= acc_q + 56'($signed(prod_s1[63:16]));
				if (32'(basis_q[r_q]) == 32'(c_q)) basic_q <= 1'b1;
			end
			S_ED: begin
				if (c_zero || real_v < min_r_q) min_r_q <= real_v;
				if (c_zero || m_v < min_m_q) min_m_q <= m_v;
				acc_q   <= '0;
				macc_q  <= '0;
				basic_q <= 1'b0;
			end
			S_SB: begin
				if (bigm_q[r_q]) msum_q <= msum_q - 40'(rhs_q[r_q]);
				else rsum_q <= rsum_q + 56'($signed(prod_s1[63:16]));
			end
			S_PICK: begin
				best_q       <= (min_m_q < 48'sd0) ? min_m_q : min_r_q;
				res_status_q <= bmsp_pkg::ST_OPTIMAL;
				res_row_q    <= 3'd0;
				res_col_q    <= 5'd0;
				res_real_q   <= sat48(rsum_q);
				res_m_q      <= 48'(msum_q);
			end
			S_TIE: begin
				if (tie_v != best_q && c_zero) res_status_q <= bmsp_pkg::ST_UNBOUNDED;
			end
			S_RB: begin
				if (take_first) begin
					best_r_q <= r_q;
					ab_q     <= coef_rd_q;
					rhsb_q   <= rhs_q[r_q];
				end
			end
			S_RC: lhs_q <= prod_s1;
			S_RD: begin
				if (better) begin
					best_r_q <= r_q;
					ab_q     <= coef_rd_q;
					rhsb_q   <= rhs_q[r_q];
				end
			end
			S_RE: begin
				if (found_q || c_zero) res_status_q <= fin_status;
				if (found_q) begin
					res_row_q <= 3'(best_r_q);
					res_col_q <= 5'(c_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	// hold the posted beat
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
			status    <= res_status_q;
			pivot_row <= res_row_q;
			pivot_col <= res_col_q;
			real_sum  <= res_real_q;
			big_m_sum <= res_m_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bmsp_checker.sv */
`default_nettype none
module bmsp_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire [2:0]         mode,
	input wire               out_valid,
	input wire               out_stall,
	input wire [1:0]         status,
	input wire [2:0]         pivot_row,
	input wire [4:0]         pivot_col,
	input wire signed [47:0] real_sum,
	input wire signed [47:0] big_m_sum
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(pivot_row)
			&& $stable(pivot_col) && $stable(real_sum) && $stable(big_m_sum))
		else $error("result beat changed while stalled");

	// pivot fields stay zero unless a pivot was found
	a_pivot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bmsp_pkg::ST_PIVOT |-> pivot_row == 3'd0 && pivot_col == 5'd0)
		else $error("pivot fields set without a pivot");

	// an evaluate beat keeps the input stalled next cycle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == bmsp_pkg::MODE_EVAL |=> in_stall)
		else $error("input not stalled after evaluate");

	// any other beat leaves the input open
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode != bmsp_pkg::MODE_EVAL |=> !in_stall)
		else $error("input stalled after a load");

endmodule

bind big_m_simplex_pivot_select_unit bmsp_checker u_bmsp_checker (.*);
`default_nettype wire
